// ===== sv/slpbh_pkg.sv =====
`default_nettype none

package slpbh_pkg;

	typedef logic [1:0] pattern_mode_t;

	localparam pattern_mode_t ModeBoot  = 2'd0;
	localparam pattern_mode_t ModeCal   = 2'd1;
	localparam pattern_mode_t ModeReady = 2'd2;
	localparam pattern_mode_t ModeError = 2'd3;

	// Register index, taken from paddr[3:2].
	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t RegLedMode         = 2'd0;
	localparam reg_idx_t RegLedActiveHigh   = 2'd1;
	localparam reg_idx_t RegButtonActiveLow = 2'd2;

	localparam logic [31:0] IdentWindowMs = 32'd1500;
	localparam logic [31:0] HoldMs        = 32'd5000;

	// All LED periods divide 6000 ms, so every pattern is decided by now_ms mod 6000.
	// 6000 = 16 * 375: the low four bits pass through and (now_ms >> 4) mod 375
	// comes from a reciprocal multiply that is exact for 28-bit operands.
	localparam logic [28:0] Recip375    = 29'd366503876;
	localparam int unsigned Recip375Sh  = 37;
	localparam logic [8:0]  Div375      = 9'd375;

	// Reciprocals for phase values below 6000.
	localparam logic [12:0] Recip25     = 13'd5243;   // (r >> 1) / 25, shift 17
	localparam int unsigned Recip25Sh   = 17;
	localparam logic [11:0] Recip125    = 12'd2098;   // (r >> 2) / 125, shift 18
	localparam int unsigned Recip125Sh  = 18;
	localparam logic [11:0] Recip15     = 12'd2185;   // (r >> 2) / 15, shift 15
	localparam int unsigned Recip15Sh   = 15;

	localparam logic [12:0] ReadyOnMs   = 13'd80;
	localparam logic [12:0] ReadyPeriod = 13'd2000;
	localparam logic [12:0] ErrPeriod   = 13'd1500;
	localparam logic [12:0] ErrFirstEnd = 13'd100;
	localparam logic [12:0] ErrSecStart = 13'd250;
	localparam logic [12:0] ErrSecEnd   = 13'd350;

	typedef struct packed {
		logic ident_act;
		logic test_run;
		logic test_led;
		logic connected;
		logic pressed;
		logic press_edge;
		logic pulse;
	} flags_t;

endpackage

`default_nettype wire

// ===== sv/status_led_pattern_and_button_hold_top.sv =====
// Throughput: one tick item per cycle while result_ready does not stall the output;
// a four-stage pipeline (input register, reciprocal product, phase mod 6000, result
// register) with per-stage ready, which each item passes through in that order.
// Reset (arst_n low, asynchronous): pipeline empty, identify deadline, press state
// and hold flag cleared, led_mode booting, LED active high, button active low.
`default_nettype none

module status_led_pattern_and_button_hold_top (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        tick_valid,
	output logic             tick_ready,
	input  wire logic [31:0] now_ms,
	input  wire logic        link_up,
	input  wire logic        button_level,
	input  wire logic        identify_request,
	input  wire logic        test_running,
	input  wire logic        test_led,

	output logic             result_valid,
	input  wire logic        result_ready,
	output logic             led_pin,
	output logic             button_pressed,
	output logic             press_edge,
	output logic             factory_reset,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import slpbh_pkg::*;

	// Configuration registers.
	pattern_mode_t led_mode_q;
	logic          led_active_high_q;
	logic          button_active_low_q;

	// Per-tick state.
	logic [31:0] identify_deadline_q;
	logic        button_was_pressed_q;
	logic [31:0] press_start_time_q;
	logic        hold_handled_q;

	// Pipeline.
	logic        v_s1, v_s2, v_s3, v_out_q;
	logic        rdy_s1, rdy_s2, rdy_s3, rdy_out;
	logic [31:0] now_s1;
	logic        conn_s1, level_s1, ident_req_s1, test_run_s1, test_led_s1;
	logic [56:0] prod_s2;
	logic [27:0] y_s2;
	logic [3:0]  low_s2;
	flags_t      flags_s2;
	logic [12:0] phase_s3;
	flags_t      flags_s3;
	logic        led_pin_q, pressed_q, press_edge_q, pulse_q;

	// Stage 1 to 2 logic.
	logic        pressed_c, edge_c, handled_c, pulse_c;
	logic [31:0] start_c, hold_c, deadline_c;
	flags_t      flags_c;

	// Stage 2 to 3 logic.
	logic [19:0] quot_c;
	logic [28:0] q375_c;
	logic [27:0] rem_c;

	// Stage 3 to output logic.
	logic [24:0] p50_c;
	logic [22:0] p500_c, p60_c;
	logic [12:0] ready_t_c, err_t_c;
	logic        pattern_c, on_c;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_mode_q          <= ModeBoot;
			led_active_high_q   <= 1'b1;
			button_active_low_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				RegLedMode:         led_mode_q          <= pwdata[1:0];
				RegLedActiveHigh:   led_active_high_q   <= pwdata[0];
				RegButtonActiveLow: button_active_low_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			RegLedMode:         prdata = {30'd0, led_mode_q};
			RegLedActiveHigh:   prdata = {31'd0, led_active_high_q};
			RegButtonActiveLow: prdata = {31'd0, button_active_low_q};
			default:            prdata = '0;
		endcase
	end

	// A stage can take a new item when it is empty or its item moves on.
	assign rdy_out    = !v_out_q || result_ready;
	assign rdy_s3     = !v_s3 || rdy_out;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign tick_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1    <= tick_valid;
			if (rdy_s2)  v_s2    <= v_s1;
			if (rdy_s3)  v_s3    <= v_s2;
			if (rdy_out) v_out_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			now_s1       <= now_ms;
			conn_s1      <= link_up;
			level_s1     <= button_level;
			ident_req_s1 <= identify_request;
			test_run_s1  <= test_running;
			test_led_s1  <= test_led;
		end
	end

	// Button and identify state are updated as an item leaves stage 1.
	always_comb begin
		pressed_c  = button_active_low_q ? !level_s1 : level_s1;
		edge_c     = pressed_c && !button_was_pressed_q;
		start_c    = edge_c ? now_s1 : press_start_time_q;
		handled_c  = edge_c ? 1'b0 : hold_handled_q;
		hold_c     = now_s1 - start_c;
		pulse_c    = pressed_c && !handled_c && (hold_c >= HoldMs);
		deadline_c = ident_req_s1 ? (now_s1 + IdentWindowMs) : identify_deadline_q;

		flags_c.ident_act  = now_s1 < deadline_c;
		flags_c.test_run   = test_run_s1;
		flags_c.test_led   = test_led_s1;
		flags_c.connected  = conn_s1;
		flags_c.pressed    = pressed_c;
		flags_c.press_edge = edge_c;
		flags_c.pulse      = pulse_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			identify_deadline_q  <= '0;
			button_was_pressed_q <= 1'b0;
			press_start_time_q   <= '0;
			hold_handled_q       <= 1'b0;
		end else if (v_s1 && rdy_s2) begin
			identify_deadline_q  <= deadline_c;
			button_was_pressed_q <= pressed_c;
			press_start_time_q   <= start_c;
			hold_handled_q       <= handled_c || pulse_c;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			prod_s2  <= {29'd0, now_s1[31:4]} * {28'd0, Recip375};
			y_s2     <= now_s1[31:4];
			low_s2   <= now_s1[3:0];
			flags_s2 <= flags_c;
		end
	end

	assign quot_c = prod_s2[Recip375Sh +: 20];
	assign q375_c = {9'd0, quot_c} * {20'd0, Div375};
	assign rem_c  = y_s2 - q375_c[27:0];

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			phase_s3 <= {rem_c[8:0], low_s2};
			flags_s3 <= flags_s2;
		end
	end

	// Half-period parity: floor(phase / half) is even while the LED is on.
	assign p50_c  = {13'd0, phase_s3[12:1]} * {12'd0, Recip25};
	assign p500_c = {12'd0, phase_s3[12:2]} * {11'd0, Recip125};
	assign p60_c  = {12'd0, phase_s3[12:2]} * {11'd0, Recip15};

	always_comb begin
		if (phase_s3 >= (ReadyPeriod << 1))
			ready_t_c = phase_s3 - (ReadyPeriod << 1);
		else if (phase_s3 >= ReadyPeriod)
			ready_t_c = phase_s3 - ReadyPeriod;
		else
			ready_t_c = phase_s3;

		if (phase_s3 >= 13'(ErrPeriod * 3))
			err_t_c = phase_s3 - 13'(ErrPeriod * 3);
		else if (phase_s3 >= (ErrPeriod << 1))
			err_t_c = phase_s3 - (ErrPeriod << 1);
		else if (phase_s3 >= ErrPeriod)
			err_t_c = phase_s3 - ErrPeriod;
		else
			err_t_c = phase_s3;

		unique case (led_mode_q)
			ModeBoot:  pattern_c = !p50_c[Recip25Sh];
			ModeCal:   pattern_c = !p500_c[Recip125Sh];
			ModeReady: pattern_c = flags_s3.connected || (ready_t_c < ReadyOnMs);
			ModeError: pattern_c = (err_t_c < ErrFirstEnd) ||
				((err_t_c > ErrSecStart) && (err_t_c < ErrSecEnd));
			default:   pattern_c = 1'b0;
		endcase

		if (flags_s3.ident_act)
			on_c = !p60_c[Recip15Sh];
		else if (flags_s3.test_run)
			on_c = flags_s3.test_led;
		else
			on_c = pattern_c;
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			led_pin_q    <= led_active_high_q ? on_c : !on_c;
			pressed_q    <= flags_s3.pressed;
			press_edge_q <= flags_s3.press_edge;
			pulse_q      <= flags_s3.pulse;
		end
	end

	assign result_valid   = v_out_q;
	assign led_pin        = led_pin_q;
	assign button_pressed = pressed_q;
	assign press_edge     = press_edge_q;
	assign factory_reset  = pulse_q;

`ifndef SYNTHESIS
	// A factory-reset pulse needs a press that started on an earlier item.
	a_pulse_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && factory_reset |-> button_pressed && !press_edge)
		else $error("factory reset without a held press");

	// The hold flag stays set while the same press continues.
	a_hold_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		hold_handled_q && button_was_pressed_q && !(v_s1 && rdy_s2)
		|=> hold_handled_q)
		else $error("hold flag dropped during a press");

	// With the output stage empty every stage has room, so a tick is taken.
	a_empty_takes_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> tick_ready)
		else $error("tick refused with empty output stage");
`endif

endmodule

`default_nettype wire
